// ===== hdl/skt_pkg.sv =====
package skt_pkg;

	// Result kinds.
	localparam logic [4:0] KIND_EOF     = 5'd0;
	localparam logic [4:0] KIND_STRING  = 5'd1;
	localparam logic [4:0] KIND_SPACE   = 5'd2;
	localparam logic [4:0] KIND_NEWLINE = 5'd3;
	localparam logic [4:0] KIND_AND     = 5'd4;
	localparam logic [4:0] KIND_OR      = 5'd5;
	localparam logic [4:0] KIND_BG      = 5'd6;
	localparam logic [4:0] KIND_PIPE    = 5'd7;
	localparam logic [4:0] KIND_LBRACE  = 5'd8;
	localparam logic [4:0] KIND_RBRACE  = 5'd9;
	localparam logic [4:0] KIND_LPAREN  = 5'd10;
	localparam logic [4:0] KIND_RPAREN  = 5'd11;
	localparam logic [4:0] KIND_SEMI    = 5'd12;
	localparam logic [4:0] KIND_LT      = 5'd13;
	localparam logic [4:0] KIND_GT      = 5'd14;
	localparam logic [4:0] KIND_QUOTE   = 5'd15;
	localparam logic [4:0] KIND_DQUOTE  = 5'd16;
	localparam logic [4:0] KIND_HASH    = 5'd17;
	localparam logic [4:0] KIND_DOLLAR  = 5'd18;

	// Held operator codes.
	localparam logic [1:0] HOLD_NONE = 2'd0;
	localparam logic [1:0] HOLD_AMP  = 2'd1;
	localparam logic [1:0] HOLD_BAR  = 2'd2;
	localparam logic [1:0] HOLD_CR   = 2'd3;

	// Class of the previous byte.
	localparam logic [1:0] CLS_BOUND = 2'd0;
	localparam logic [1:0] CLS_STR   = 2'd1;
	localparam logic [1:0] CLS_SPACE = 2'd2;

	// Character codes.
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Depth of the result queue.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [4:0] kind;
		logic [7:0] value_byte;
		logic       starts_token;
		logic       last_of_run;
	} result_t;

	// Operator kind of a single byte; KIND_EOF when the byte is no operator.
	function automatic logic [4:0] single_op(input logic [7:0] b);
		logic [4:0] k;
		case (b)
			CH_AMP:    k = KIND_BG;
			CH_BAR:    k = KIND_PIPE;
			CH_LBRACE: k = KIND_LBRACE;
			CH_RBRACE: k = KIND_RBRACE;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_SEMI:   k = KIND_SEMI;
			CH_LT:     k = KIND_LT;
			CH_GT:     k = KIND_GT;
			CH_CR:     k = KIND_NEWLINE;
			CH_LF:     k = KIND_NEWLINE;
			CH_QUOTE:  k = KIND_QUOTE;
			CH_DQUOTE: k = KIND_DQUOTE;
			CH_HASH:   k = KIND_HASH;
			CH_DOLLAR: k = KIND_DOLLAR;
			default:   k = KIND_EOF;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/shell_token_splitter_core.sv =====
// Channel   Direction  Contents
// s_axis    in         tdata = in_byte, tuser = end_of_input
// m_axis    out        tuser = kind, tdata = value_byte, starts_token; tlast = last_of_run
//
// Each accepted input item is classified in the cycle it arrives and yields zero, one
// or two results, which are written at once into a four-entry result queue.
// Input is taken every cycle while at least two queue entries are free, so items giving
// one result each run at one item per cycle while m_axis accepts; an item that flushes
// a held operator and adds a result of its own writes two results into the queue.
// Reset clears the held operator, the previous byte class and the queue; a stall on
// m_axis fills the queue until under two entries are free; then s_axis_tready drops.
module shell_token_splitter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tuser,   // [0] end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] value_byte, [8] starts_token, [15:9] zero
	output logic [4:0]  m_axis_tuser,   // [4:0] kind
	output logic        m_axis_tlast    // last_of_run
);

	// Tokenizer state.
	logic [1:0] held_q;
	logic [1:0] prev_q;

	// Result queue.
	skt_pkg::result_t                   queue_q [skt_pkg::QUEUE_DEPTH];
	logic [skt_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [skt_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [skt_pkg::QCNT_W-1:0]         count_q;

	logic       in_fire;
	logic       out_fire;
	logic [7:0] b;
	logic       is_end;
	logic [4:0] op;
	logic       is_blank;
	logic       is_word;

	// Flush of a held operator that the new byte does not complete.
	skt_pkg::result_t flush_res;
	logic             flush_vld;
	// Result of the new byte handled as if nothing were held.
	skt_pkg::result_t fresh_res;
	logic             fresh_vld;
	logic [1:0]       fresh_held;
	logic [1:0]       fresh_prev;

	skt_pkg::result_t res0;
	skt_pkg::result_t res1;
	logic [1:0]       n_res;
	logic [1:0]       held_d;
	logic [1:0]       prev_d;
	logic             combine;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	assign s_axis_tready = (count_q <= skt_pkg::QCNT_W'(skt_pkg::QUEUE_DEPTH - 2));
	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = {7'b0000000, queue_q[rd_ptr_q].starts_token,
		queue_q[rd_ptr_q].value_byte};
	assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last_of_run;

	assign b        = s_axis_tdata;
	assign is_end   = s_axis_tuser;
	assign op       = skt_pkg::single_op(b);
	assign is_blank = (b == skt_pkg::CH_SPACE) || (b == skt_pkg::CH_TAB);
	assign is_word  = !is_blank && (op == skt_pkg::KIND_EOF);

	// Flush of the held operator.
	always_comb begin
		flush_res = '{kind: skt_pkg::KIND_EOF, value_byte: 8'h00, starts_token: 1'b1,
			last_of_run: 1'b0};
		flush_vld = 1'b1;
		case (held_q)
			skt_pkg::HOLD_AMP: flush_res.kind = skt_pkg::KIND_BG;
			skt_pkg::HOLD_BAR: flush_res.kind = skt_pkg::KIND_PIPE;
			skt_pkg::HOLD_CR:  flush_res.kind = skt_pkg::KIND_NEWLINE;
			default:           flush_vld = 1'b0;
		endcase
	end

	// A fresh byte: blank run, word run, held operator or plain operator.
	always_comb begin
		fresh_res  = '{kind: op, value_byte: 8'h00, starts_token: 1'b1, last_of_run: 1'b0};
		fresh_vld  = 1'b1;
		fresh_held = skt_pkg::HOLD_NONE;
		fresh_prev = skt_pkg::CLS_BOUND;
		if (is_blank) begin
			fresh_res.kind         = skt_pkg::KIND_SPACE;
			fresh_res.value_byte   = b;
			fresh_res.starts_token = (prev_q != skt_pkg::CLS_SPACE);
			fresh_prev             = skt_pkg::CLS_SPACE;
		end else if (is_word) begin
			fresh_res.kind         = skt_pkg::KIND_STRING;
			fresh_res.value_byte   = b;
			fresh_res.starts_token = (prev_q != skt_pkg::CLS_STR);
			fresh_prev             = skt_pkg::CLS_STR;
		end else if (b == skt_pkg::CH_AMP) begin
			fresh_vld  = 1'b0;
			fresh_held = skt_pkg::HOLD_AMP;
		end else if (b == skt_pkg::CH_BAR) begin
			fresh_vld  = 1'b0;
			fresh_held = skt_pkg::HOLD_BAR;
		end else if (b == skt_pkg::CH_CR) begin
			fresh_vld  = 1'b0;
			fresh_held = skt_pkg::HOLD_CR;
		end
	end

	// The held operator is completed by the matching second byte.
	assign combine = !is_end && (
		((held_q == skt_pkg::HOLD_AMP) && (b == skt_pkg::CH_AMP)) ||
		((held_q == skt_pkg::HOLD_BAR) && (b == skt_pkg::CH_BAR)) ||
		((held_q == skt_pkg::HOLD_CR)  && (b == skt_pkg::CH_LF)));

	// Assemble up to two results for this item and the next state.
	always_comb begin
		skt_pkg::result_t second;
		logic             second_vld;
		second     = fresh_res;
		second_vld = fresh_vld;
		held_d     = fresh_held;
		prev_d     = fresh_prev;
		if (is_end) begin
			second     = '{kind: skt_pkg::KIND_EOF, value_byte: 8'h00, starts_token: 1'b1,
				last_of_run: 1'b0};
			second_vld = 1'b1;
			held_d     = skt_pkg::HOLD_NONE;
			prev_d     = skt_pkg::CLS_BOUND;
		end
		res0 = flush_res;
		res1 = second;
		if (combine) begin
			res0      = '{kind: skt_pkg::KIND_EOF, value_byte: 8'h00, starts_token: 1'b1,
				last_of_run: 1'b1};
			res0.kind = (held_q == skt_pkg::HOLD_AMP) ? skt_pkg::KIND_AND :
				(held_q == skt_pkg::HOLD_BAR) ? skt_pkg::KIND_OR : skt_pkg::KIND_NEWLINE;
			n_res     = 2'd1;
			held_d    = skt_pkg::HOLD_NONE;
			prev_d    = prev_q;
		end else if (flush_vld) begin
			n_res = second_vld ? 2'd2 : 2'd1;
			if (second_vld) begin
				res1.last_of_run = 1'b1;
			end else begin
				res0.last_of_run = 1'b1;
			end
		end else begin
			res0             = second;
			res0.last_of_run = 1'b1;
			n_res            = second_vld ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= skt_pkg::HOLD_NONE;
			prev_q   <= skt_pkg::CLS_BOUND;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_fire) begin
				held_q   <= held_d;
				prev_q   <= prev_d;
				wr_ptr_q <= wr_ptr_q + skt_pkg::QPTR_W'(n_res);
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + skt_pkg::QPTR_W'(1);
			end
			count_q <= count_q + (in_fire ? skt_pkg::QCNT_W'(n_res) : '0)
				- skt_pkg::QCNT_W'(out_fire);
		end
	end

	// Queue storage needs no reset.
	always_ff @(posedge clk) begin
		if (in_fire && (n_res != 2'd0)) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (in_fire && (n_res == 2'd2)) begin
			queue_q[wr_ptr_q + skt_pkg::QPTR_W'(1)] <= res1;
		end
	end

endmodule
